### rtl/rha_pkg.sv
// ----------------------------------------------------------------------------
// rha_pkg
// Shared types, constants and the correction-table builder of the read
// haplotype assigner.
// ----------------------------------------------------------------------------
package rha_pkg;

  localparam int unsigned DEF_LOG_FRAC_BITS = 8;
  localparam int unsigned DEF_TABLE_DEPTH   = 256;
  localparam int unsigned TAB_STEP_BITS     = 5;
  localparam int unsigned CORR_FRAC         = 16;
  localparam logic [15:0] POST_LIMIT        = 16'd2998;
  localparam logic [9:0]  PHRED_MAX         = 10'd1023;
  localparam logic [15:0] COUNT_MAX         = 16'hFFFF;
  localparam logic [7:0]  RST_QUAL_OFFSET   = 8'd33;
  localparam logic [7:0]  RST_MIN_QUAL      = 8'd10;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] LOG2_10_Q30 = 64'd3566893132;
  localparam logic [63:0] LN2_Q30     = 64'd744261118;
  localparam logic [63:0] LOG10_2_Q30 = 64'd323228497;

  typedef enum logic [0:0] {
    CFG_QUALITY_OFFSET = 1'b0,
    CFG_MIN_QUALITY    = 1'b1
  } rha_cfg_idx_e;

  typedef struct packed {
    logic [7:0] quality_offset;
    logic [7:0] min_quality;
  } rha_cfg_t;

  typedef struct packed {
    logic        phase_known;
    logic        allele_matches;
    logic [7:0]  raw_quality;
    logic [15:0] log_correct;
    logic [19:0] snp_index;
    logic        last_of_read;
  } rha_obs_t;

  typedef struct packed {
    logic        any_used;
    logic [19:0] first_snp;
    logic [15:0] used_count;
  } rha_meta_t;

  typedef struct packed {
    logic [31:0] sum_hap0;
    logic [31:0] sum_hap1;
    rha_meta_t   meta;
  } rha_fin_t;

  typedef struct packed {
    logic        haplotype;
    logic [9:0]  phred_quality;
    logic        confident;
    logic [19:0] first_snp;
    logic [15:0] used_count;
  } rha_res_t;

  // 2^-t, t and result in Q30
  function automatic logic [63:0] pow2_neg(input logic [63:0] t);
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] g;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    n = t >> 30;
    f = t & (Q30_ONE - 64'd1);
    g = (f * LN2_Q30) >> 30;
    term = Q30_ONE;
    pos  = Q30_ONE;
    neg  = 64'd0;
    term = ((term * g) >> 30) / 64'd1;  neg += term;
    term = ((term * g) >> 30) / 64'd2;  pos += term;
    term = ((term * g) >> 30) / 64'd3;  neg += term;
    term = ((term * g) >> 30) / 64'd4;  pos += term;
    term = ((term * g) >> 30) / 64'd5;  neg += term;
    term = ((term * g) >> 30) / 64'd6;  pos += term;
    term = ((term * g) >> 30) / 64'd7;  neg += term;
    term = ((term * g) >> 30) / 64'd8;  pos += term;
    term = ((term * g) >> 30) / 64'd9;  neg += term;
    term = ((term * g) >> 30) / 64'd10; pos += term;
    term = ((term * g) >> 30) / 64'd11; neg += term;
    term = ((term * g) >> 30) / 64'd12; pos += term;
    term = ((term * g) >> 30) / 64'd13; neg += term;
    term = ((term * g) >> 30) / 64'd14; pos += term;
    term = ((term * g) >> 30) / 64'd15; neg += term;
    term = ((term * g) >> 30) / 64'd16; pos += term;
    term = ((term * g) >> 30) / 64'd17; neg += term;
    term = ((term * g) >> 30) / 64'd18; pos += term;
    term = ((term * g) >> 30) / 64'd19; neg += term;
    term = ((term * g) >> 30) / 64'd20; pos += term;
    term = ((term * g) >> 30) / 64'd21; neg += term;
    term = ((term * g) >> 30) / 64'd22; pos += term;
    term = ((term * g) >> 30) / 64'd23; neg += term;
    term = ((term * g) >> 30) / 64'd24; pos += term;
    if (n >= 64'd63) begin
      return 64'd0;
    end
    return (pos - neg) >> n;
  endfunction

  // log2(z), z in Q30 within [1, 2], result in Q30
  function automatic logic [63:0] log2_q30(input logic [63:0] z_in);
    logic [63:0] z;
    logic [63:0] r;
    z = z_in;
    r = 64'd0;
    if (z >= (Q30_ONE << 1)) begin
      return Q30_ONE;
    end
    for (int b = 29; b >= 0; b--) begin
      z = (z * z) >> 30;
      if (z >= (Q30_ONE << 1)) begin
        z = z >> 1;
        r = r | (64'd1 << b);
      end
    end
    return r;
  endfunction

  // log10(1 + 10^-(i / 2^TAB_STEP_BITS)) with CORR_FRAC fraction bits
  function automatic logic [15:0] corr_entry(input int unsigned i);
    logic [63:0] t;
    logic [63:0] y;
    logic [63:0] l2;
    logic [63:0] l10;
    logic [63:0] rnd;
    t   = (64'(i) * LOG2_10_Q30) >> TAB_STEP_BITS;
    y   = pow2_neg(t);
    l2  = log2_q30(Q30_ONE + y);
    l10 = (l2 * LOG10_2_Q30) >> 30;
    rnd = (l10 + 64'd8192) >> 14;
    return rnd[15:0];
  endfunction

endpackage

### rtl/rha_accum.sv
// ----------------------------------------------------------------------------
// rha_accum
// Observation register and per-read accumulator: filters observations,
// updates both saturating log-likelihood sums and hands a finished read on.
// ----------------------------------------------------------------------------
module rha_accum import rha_pkg::*; #(
  parameter int unsigned LOG_FRAC_BITS = DEF_LOG_FRAC_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rha_cfg_t cfg_i,
  input  logic     obs_valid_i,
  output logic     obs_ready_o,
  input  rha_obs_t obs_i,
  output logic     fin_valid_o,
  input  logic     fin_ready_i,
  output rha_fin_t fin_o
);

  localparam int unsigned ERR_W = LOG_FRAC_BITS + 8;

  typedef logic [ERR_W-1:0] err_tab_t [256];

  function automatic err_tab_t build_err();
    err_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = ERR_W'((64'(i) << LOG_FRAC_BITS) / 64'd10);
    end
    return tab;
  endfunction

  localparam err_tab_t ERR_TAB = build_err();

  function automatic logic [31:0] sat_add(input logic [31:0] s, input logic signed [32:0] inc);
    logic signed [32:0] r;
    r = $signed({s[31], s}) + inc;
    if (r[32] != r[31]) begin
      return r[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return r[31:0];
  endfunction

  rha_obs_t obs_q;
  logic     obs_v_q;
  rha_fin_t fin_q;
  logic     fin_v_q;

  logic [31:0] sum0_q, sum0_d;
  logic [31:0] sum1_q, sum1_d;
  rha_meta_t   meta_q, meta_d;

  logic               fin_rdy;
  logic               adv;
  logic [8:0]         q9;
  logic               used;
  logic [ERR_W-1:0]   err_mag;
  logic signed [32:0] err_s;
  logic signed [32:0] lc_s;
  logic signed [32:0] inc0;
  logic signed [32:0] inc1;

  assign fin_rdy     = !fin_v_q || fin_ready_i;
  assign adv         = obs_v_q && (!obs_q.last_of_read || fin_rdy);
  assign obs_ready_o = !obs_v_q || adv;

  always_comb begin
    q9      = {1'b0, obs_q.raw_quality} - {1'b0, cfg_i.quality_offset};
    used    = obs_q.phase_known && !q9[8] && (q9[7:0] >= cfg_i.min_quality);
    err_mag = ERR_TAB[q9[7:0]];
    err_s   = -$signed(33'(err_mag));
    lc_s    = 33'($signed(obs_q.log_correct));
    inc0    = obs_q.allele_matches ? lc_s : err_s;
    inc1    = obs_q.allele_matches ? err_s : lc_s;
    sum0_d  = sum0_q;
    sum1_d  = sum1_q;
    meta_d  = meta_q;
    if (used) begin
      sum0_d = sat_add(sum0_q, inc0);
      sum1_d = sat_add(sum1_q, inc1);
      if (!meta_q.any_used) begin
        meta_d.any_used  = 1'b1;
        meta_d.first_snp = obs_q.snp_index;
      end
      if (meta_q.used_count != COUNT_MAX) begin
        meta_d.used_count = meta_q.used_count + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obs_v_q <= 1'b0;
    end else if (obs_ready_o) begin
      obs_v_q <= obs_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (obs_ready_o && obs_valid_i) begin
      obs_q <= obs_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum0_q <= '0;
      sum1_q <= '0;
      meta_q <= '0;
    end else if (adv) begin
      if (obs_q.last_of_read) begin
        sum0_q <= '0;
        sum1_q <= '0;
        meta_q <= '0;
      end else begin
        sum0_q <= sum0_d;
        sum1_q <= sum1_d;
        meta_q <= meta_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (fin_rdy) begin
      fin_v_q <= adv && obs_q.last_of_read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_rdy && adv && obs_q.last_of_read) begin
      fin_q.sum_hap0 <= sum0_d;
      fin_q.sum_hap1 <= sum1_d;
      fin_q.meta     <= meta_d;
    end
  end

  assign fin_valid_o = fin_v_q;
  assign fin_o       = fin_q;

endmodule

### rtl/rha_score.sv
// ----------------------------------------------------------------------------
// rha_score
// Read scoring pipeline: sum difference, log-sum-exp correction lookup,
// phred quality and confidence, ending in the result register.
// ----------------------------------------------------------------------------
module rha_score import rha_pkg::*; #(
  parameter int unsigned LOG_FRAC_BITS = DEF_LOG_FRAC_BITS,
  parameter int unsigned TABLE_DEPTH   = DEF_TABLE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fin_valid_i,
  output logic     fin_ready_o,
  input  rha_fin_t fin_i,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output rha_res_t res_o
);

  localparam int unsigned TAB_AW = $clog2(TABLE_DEPTH);
  localparam int unsigned SH_W   = 32 + TAB_STEP_BITS;

  typedef logic [15:0] corr_tab_t [TABLE_DEPTH];

  function automatic corr_tab_t build_corr();
    corr_tab_t tab;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tab[i] = corr_entry(i);
    end
    return tab;
  endfunction

  localparam corr_tab_t CORR_TAB = build_corr();

  logic        a_v_q, b_v_q, c_v_q;
  logic        a_rdy, b_rdy, c_rdy;
  logic        a_hap0_q, b_hap0_q;
  logic [31:0] a_d_q, b_d_q;
  logic [15:0] b_entry_q;
  rha_meta_t   a_meta_q, b_meta_q;
  rha_res_t    res_q;

  logic signed [32:0] diff;
  logic signed [32:0] ndiff;
  logic               hap0;
  logic [31:0]        d_abs;
  logic [SH_W-1:0]    idx_w;
  logic               in_range;
  logic [15:0]        entry;
  logic [32:0]        corr_w;
  logic [16:0]        corr;
  logic [32:0]        x;
  logic [36:0]        x10;
  logic [36:0]        ph;
  logic [9:0]         phred;

  assign c_rdy       = !c_v_q || res_ready_i;
  assign b_rdy       = !b_v_q || c_rdy;
  assign a_rdy       = !a_v_q || b_rdy;
  assign fin_ready_o = a_rdy;

  always_comb begin
    diff  = $signed({fin_i.sum_hap0[31], fin_i.sum_hap0})
          - $signed({fin_i.sum_hap1[31], fin_i.sum_hap1});
    ndiff = -diff;
    hap0  = !diff[32] && (diff != '0);
    d_abs = hap0 ? diff[31:0] : ndiff[31:0];
  end

  always_comb begin
    idx_w    = {a_d_q, {TAB_STEP_BITS{1'b0}}} >> LOG_FRAC_BITS;
    in_range = idx_w < SH_W'(TABLE_DEPTH);
    entry    = in_range ? CORR_TAB[idx_w[TAB_AW-1:0]] : 16'd0;
  end

  always_comb begin
    corr_w = (33'(b_entry_q) << LOG_FRAC_BITS) + (33'd1 << (CORR_FRAC - 1));
    corr   = corr_w[32:16];
    x      = 33'(b_d_q) + 33'(corr);
    x10    = (37'(x) << 3) + (37'(x) << 1);
    ph     = x10 >> LOG_FRAC_BITS;
    phred  = (ph > 37'(PHRED_MAX)) ? PHRED_MAX : ph[9:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_v_q <= fin_valid_i;
      end
      if (b_rdy) begin
        b_v_q <= a_v_q;
      end
      if (c_rdy) begin
        c_v_q <= b_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && fin_valid_i) begin
      a_hap0_q <= hap0;
      a_d_q    <= d_abs;
      a_meta_q <= fin_i.meta;
    end
    if (b_rdy && a_v_q) begin
      b_hap0_q  <= a_hap0_q;
      b_d_q     <= a_d_q;
      b_entry_q <= entry;
      b_meta_q  <= a_meta_q;
    end
    if (c_rdy && b_v_q) begin
      res_q.haplotype     <= !b_hap0_q;
      res_q.phred_quality <= phred;
      res_q.confident     <= b_meta_q.any_used && (b_entry_q <= POST_LIMIT);
      res_q.first_snp     <= b_meta_q.first_snp;
      res_q.used_count    <= b_meta_q.used_count;
    end
  end

  assign res_valid_o = c_v_q;
  assign res_o       = res_q;

endmodule

### rtl/read_haplotype_assigner_top.sv
// ----------------------------------------------------------------------------
// read_haplotype_assigner_top
// Assigns each sequencing read to its more likely haplotype from a stream of
// allele observations and reports a phred-style quality for the call.
// ----------------------------------------------------------------------------
// One observation beat is taken every clock, unless the last beat of a read waits
// on a finished-read register that is still held. The accumulate step that adds a
// beat to the two running sums closes on the observation register, so
// back-to-back beats of one read never stall. A read result reaches the master
// side through the observation register, finished-read register, difference,
// lookup and result register; backpressure on the master side holds the pipeline
// stage by stage. The correction table is a constant, so there is no fill after reset.
// Configuration writes belong between reads, with the pipeline drained.
module read_haplotype_assigner_top import rha_pkg::*; #(
  parameter int unsigned LOG_FRAC_BITS = DEF_LOG_FRAC_BITS,
  parameter int unsigned TABLE_DEPTH   = DEF_TABLE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // phase_known, allele_matches, raw_quality[7:0], log_correct[15:0],
  // snp_index[19:0], zero fill
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // haplotype, phred_quality[9:0], confident, first_snp[19:0],
  // used_count[15:0]
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);

  rha_cfg_t cfg_q;
  rha_obs_t obs;
  rha_fin_t fin;
  logic     fin_valid;
  logic     fin_ready;
  rha_res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quality_offset <= RST_QUAL_OFFSET;
      cfg_q.min_quality    <= RST_MIN_QUAL;
    end else if (cfg_we_i) begin
      unique case (rha_cfg_idx_e'(cfg_idx_i))
        CFG_QUALITY_OFFSET: cfg_q.quality_offset <= cfg_wdata_i;
        CFG_MIN_QUALITY:    cfg_q.min_quality    <= cfg_wdata_i;
      endcase
    end
  end

  assign obs.phase_known    = s_axis_tdata[0];
  assign obs.allele_matches = s_axis_tdata[1];
  assign obs.raw_quality    = s_axis_tdata[9:2];
  assign obs.log_correct    = s_axis_tdata[25:10];
  assign obs.snp_index      = s_axis_tdata[45:26];
  assign obs.last_of_read   = s_axis_tlast;

  rha_accum #(
    .LOG_FRAC_BITS(LOG_FRAC_BITS)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .obs_valid_i(s_axis_tvalid),
    .obs_ready_o(s_axis_tready),
    .obs_i      (obs),
    .fin_valid_o(fin_valid),
    .fin_ready_i(fin_ready),
    .fin_o      (fin)
  );

  rha_score #(
    .LOG_FRAC_BITS(LOG_FRAC_BITS),
    .TABLE_DEPTH  (TABLE_DEPTH)
  ) u_score (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fin_valid_i(fin_valid),
    .fin_ready_o(fin_ready),
    .fin_i      (fin),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {res.used_count, res.first_snp, res.confident,
                         res.phred_quality, res.haplotype};

  a_empty_out_takes_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty result register");

  a_confident_needs_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.confident |-> res.used_count != 16'd0)
    else $error("confident result without a used observation");

  a_no_use_no_snp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.used_count == 16'd0 |-> res.first_snp == 20'd0)
    else $error("first snp reported for a read with no used observation");

  a_fin_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid && !fin_ready |=> fin_valid && $stable(fin))
    else $error("finished read dropped or changed while stalled");

endmodule

### tb/read_haplotype_assigner_top_tb.sv
// ----------------------------------------------------------------------------
// read_haplotype_assigner_top_tb
// Streams allele observations of sequencing reads into the assigner and checks
// every read call against an in-bench model of the two log-likelihood sums,
// the log-sum-exp correction and the confidence test. Covers skipped beats,
// ties, table overrun, long reads with wide sum gaps and several register
// settings, with bursty input and a patterned output stall.
// ----------------------------------------------------------------------------
module read_haplotype_assigner_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rha_pkg::*;

  localparam longint LL_MAX = 64'sd2147483647;
  localparam longint LL_MIN = -64'sd2147483648;
  localparam int     ITEM_TARGET = 550;

  typedef struct {
    bit        hap;
    bit [9:0]  phred;
    bit        conf;
    bit [19:0] snp;
    bit [15:0] cnt;
  } read_call_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // phase_known, allele_matches, raw_quality[7:0], log_correct[15:0],
  // snp_index[19:0], zero fill
  logic [47:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // haplotype, phred_quality[9:0], confident, first_snp[19:0], used_count[15:0]
  logic [47:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [7:0]  cfg_wdata_i;

  read_haplotype_assigner_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // model state
  logic [15:0] corr_lut [DEF_TABLE_DEPTH];
  logic [7:0]  qual_offset = RST_QUAL_OFFSET;
  logic [7:0]  qual_min    = RST_MIN_QUAL;
  longint      hap0_ll;
  longint      hap1_ll;
  logic [19:0] lead_snp;
  bit          read_used;
  int unsigned used_obs;
  read_call_t  calls_due [$];

  int beats_sent;
  int calls_seen;
  int reg_writes;
  int errors;
  int burst_left;
  int rx_cyc;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic longint unsigned exp2_neg_q30(longint unsigned t);
    longint unsigned n;
    longint unsigned f;
    longint unsigned g;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    n    = t >> 30;
    f    = t & (Q30_ONE - 64'd1);
    g    = (f * LN2_Q30) >> 30;
    term = Q30_ONE;
    pos  = Q30_ONE;
    neg  = 0;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * g) >> 30) / 64'(k);
      if (k % 2 == 1) begin
        neg += term;
      end else begin
        pos += term;
      end
    end
    if (n >= 63) begin
      return 0;
    end
    return (pos - neg) >> n;
  endfunction

  function automatic longint unsigned log2_unit_q30(longint unsigned z0);
    longint unsigned z;
    longint unsigned r;
    z = z0;
    r = 0;
    if (z >= 2 * Q30_ONE) begin
      return Q30_ONE;
    end
    for (int b = 29; b >= 0; b--) begin
      z = (z * z) >> 30;
      if (z >= 2 * Q30_ONE) begin
        z = z >> 1;
        r = r | (64'd1 << b);
      end
    end
    return r;
  endfunction

  function automatic void fill_corr_lut();
    longint unsigned t;
    longint unsigned l10;
    for (int i = 0; i < DEF_TABLE_DEPTH; i++) begin
      t   = (64'(i) * LOG2_10_Q30) >> TAB_STEP_BITS;
      l10 = (log2_unit_q30(Q30_ONE + exp2_neg_q30(t)) * LOG10_2_Q30) >> 30;
      corr_lut[i] = 16'((l10 + 64'd8192) >> 14);
    end
  endfunction

  function automatic longint sat32(longint v);
    if (v > LL_MAX) begin
      return LL_MAX;
    end
    if (v < LL_MIN) begin
      return LL_MIN;
    end
    return v;
  endfunction

  function automatic void clear_read();
    hap0_ll   = 0;
    hap1_ll   = 0;
    lead_snp  = '0;
    read_used = 1'b0;
    used_obs  = 0;
  endfunction

  function automatic void fold_observation(rha_obs_t o);
    int              q;
    longint          lc;
    longint          err;
    longint unsigned d;
    longint unsigned idx;
    longint unsigned entry;
    longint unsigned corr;
    longint unsigned phred;
    read_call_t      c;
    q  = int'(o.raw_quality) - int'(qual_offset);
    lc = longint'($signed(o.log_correct));
    if (o.phase_known && q >= int'(qual_min)) begin
      err = -longint'((q * 256) / 10);
      if (!read_used) begin
        lead_snp  = o.snp_index;
        read_used = 1'b1;
      end
      if (used_obs < 65535) begin
        used_obs++;
      end
      if (o.allele_matches) begin
        hap0_ll = sat32(hap0_ll + lc);
        hap1_ll = sat32(hap1_ll + err);
      end else begin
        hap0_ll = sat32(hap0_ll + err);
        hap1_ll = sat32(hap1_ll + lc);
      end
    end
    if (!o.last_of_read) begin
      return;
    end
    c.hap = !(hap0_ll > hap1_ll);
    d     = c.hap ? longint'(hap1_ll - hap0_ll) : longint'(hap0_ll - hap1_ll);
    idx   = (d << TAB_STEP_BITS) >> DEF_LOG_FRAC_BITS;
    entry = (idx < DEF_TABLE_DEPTH) ? 64'(corr_lut[idx]) : 0;
    corr  = ((entry << DEF_LOG_FRAC_BITS) + (64'd1 << (CORR_FRAC - 1))) >> CORR_FRAC;
    phred = ((d + corr) * 10) >> DEF_LOG_FRAC_BITS;
    if (phred > 64'(PHRED_MAX)) begin
      phred = 64'(PHRED_MAX);
    end
    c.phred = phred[9:0];
    c.conf  = read_used && entry <= 64'(POST_LIMIT);
    c.snp   = read_used ? lead_snp : '0;
    c.cnt   = used_obs[15:0];
    calls_due.push_back(c);
    clear_read();
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("[%0t] MISMATCH call %0d: %s", $realtime, calls_seen, what);
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin
    read_call_t c;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (calls_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", m_axis_tdata));
      end else begin
        c = calls_due.pop_front();
        check_field("haplotype", m_axis_tdata[0], c.hap);
        check_field("phred_quality", m_axis_tdata[10:1], c.phred);
        check_field("confident", m_axis_tdata[11], c.conf);
        check_field("first_snp", m_axis_tdata[31:12], c.snp);
        check_field("used_count", m_axis_tdata[47:32], c.cnt);
      end
      calls_seen++;
    end
  end

  always @(negedge clk_i) begin
    rx_cyc++;
    case ((rx_cyc / 150) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (rx_cyc % 7) < 3;
      default: m_axis_tready <= $urandom_range(0, 9) != 0;
    endcase
  end

  function automatic rha_obs_t mk_obs(bit ph, bit mt, int raw, int lc, int snp, bit last);
    rha_obs_t o;
    o.phase_known    = ph;
    o.allele_matches = mt;
    o.raw_quality    = raw[7:0];
    o.log_correct    = lc[15:0];
    o.snp_index      = snp[19:0];
    o.last_of_read   = last;
    return o;
  endfunction

  task automatic send_obs(rha_obs_t o);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, o.snp_index, o.log_correct, o.raw_quality,
                      o.allele_matches, o.phase_known};
    s_axis_tlast  <= o.last_of_read;
    do @(posedge clk_i); while (!s_axis_tready);
    fold_observation(o);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // hold off until every pending call is out
  task automatic wait_calls_out();
    s_axis_tvalid <= 1'b0;
    while (calls_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic settle();
    wait_calls_out();
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(rha_cfg_idx_e idx, logic [7:0] val);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_QUALITY_OFFSET) begin
      qual_offset = val;
    end else begin
      qual_min = val;
    end
    reg_writes++;
  endtask

  task automatic send_random_read(int max_len);
    int len;
    int lo;
    int raw;
    int lc;
    len = $urandom_range(1, max_len);
    lo  = int'(qual_offset) + int'(qual_min);
    for (int i = 0; i < len; i++) begin
      if (lo > 255 || $urandom_range(0, 6) == 0) begin
        raw = $urandom_range(0, 255);
      end else begin
        raw = $urandom_range(lo, 255);
      end
      case ($urandom_range(0, 9))
        0: lc = $urandom_range(1, 32767);
        1: lc = ($urandom_range(0, 1) == 1) ? -32768 : 0;
        2, 3, 4, 5: lc = -int'($urandom_range(0, 512));
        default: lc = -int'($urandom_range(0, 32768));
      endcase
      send_obs(mk_obs($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)), raw, lc,
                      int'($urandom() & 32'hFFFFF), i == len - 1));
    end
  endtask

  task automatic test_directed();
    send_obs(mk_obs(0, 0, 43, 0, 5, 1));
    send_obs(mk_obs(1, 1, 20, -100, 6, 1));
    send_obs(mk_obs(1, 0, 42, -100, 7, 1));
    send_obs(mk_obs(1, 1, 43, -256, 20'hFFFFF, 1));
    send_obs(mk_obs(1, 0, 255, 32767, 0, 0));
    send_obs(mk_obs(0, 1, 255, -5, 12345, 1));
    send_obs(mk_obs(1, 1, 255, -32768, 20'h80000, 1));
    send_obs(mk_obs(1, 1, 0, -1, 1, 0));
    send_obs(mk_obs(1, 0, 255, -32768, 2, 0));
    send_obs(mk_obs(1, 1, 200, -10, 3, 0));
    send_obs(mk_obs(1, 1, 255, 0, 4, 1));
    send_obs(mk_obs(1, 1, 255, 0, 9, 1));
    for (int i = 0; i < 5; i++) begin
      send_obs(mk_obs(1, 1, 255, 0, 10 + i, i == 4));
    end
    send_obs(mk_obs(1, 1, 53, -256, 20'h5A5A5, 1));
    send_obs(mk_obs(1, 1, 52, -256, 20'hA5A5A, 1));
    send_obs(mk_obs(1, 0, 52, -256, 20'h0F0F0, 1));
  endtask

  task automatic test_reg_settings();
    logic [7:0] offs [6] = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0};
    logic [7:0] mins [6] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0};
    offs[4] = 8'($urandom_range(0, 255));
    mins[4] = 8'($urandom_range(0, 255));
    offs[5] = 8'($urandom_range(0, 63));
    mins[5] = 8'($urandom_range(0, 40));
    for (int s = 0; s < 6; s++) begin
      write_reg(CFG_QUALITY_OFFSET, offs[s]);
      write_reg(CFG_MIN_QUALITY, mins[s]);
      send_obs(mk_obs(1, 1, 255, -7, 20'h00001, 1));
      send_obs(mk_obs(1, 0, int'(offs[s]) + int'(mins[s]), -300, 20'h00002, 1));
      for (int r = 0; r < 6; r++) begin
        send_random_read(6);
      end
    end
  endtask

  // drive one long read with a one-sided sum gap
  task automatic send_long_read(bit match, int lc, int len);
    for (int i = 0; i < len; i++) begin
      send_obs(mk_obs(1, match, 255, lc, int'($urandom() & 32'hFFFFF), i == len - 1));
    end
  endtask

  task automatic test_long_reads();
    write_reg(CFG_QUALITY_OFFSET, 8'd0);
    write_reg(CFG_MIN_QUALITY, 8'd255);
    send_long_read(1'b1, -32768, 40);
    send_long_read(1'b1, 32767, 40);
    send_long_read(1'b0, 32767, 40);
  endtask

  task automatic test_random_reads();
    write_reg(CFG_QUALITY_OFFSET, RST_QUAL_OFFSET);
    write_reg(CFG_MIN_QUALITY, RST_MIN_QUAL);
    while (beats_sent < ITEM_TARGET - 2) begin
      if ($urandom_range(0, 24) == 0) begin
        write_reg(CFG_QUALITY_OFFSET, 8'($urandom_range(0, 63)));
        write_reg(CFG_MIN_QUALITY, 8'($urandom_range(0, 40)));
      end else if ($urandom_range(0, 14) == 0) begin
        wait_calls_out();
      end
      send_random_read(12);
    end
    // pause in the middle of a read, then finish it
    send_obs(mk_obs(1, 1, 90, -40, 20'h12345, 0));
    wait_calls_out();
    send_obs(mk_obs(1, 0, 90, -40, 20'h54321, 1));
  endtask

  initial begin
    #2_000_000;
    $display("Timeout with %0d calls pending", calls_due.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_QUALITY_OFFSET;
    cfg_wdata_i   = '0;
    fill_corr_lut();
    clear_read();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_reg_settings();
    test_long_reads();
    test_random_reads();
    settle();

    $display("Covered %0d observation beats and %0d read calls over %0d register writes,",
             beats_sent, calls_seen, reg_writes);
    $display("including long one-sided reads past the table, with bursty input and stalls.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
